// ----- design/gshd_pkg.sv -----
// Shared constants, codes and types of the gate structural hash deduplicator.
package gshd_pkg;

    localparam int BUCKETS = 1024;
    localparam int WAYS    = 4;
    localparam int IDX_W   = $clog2(BUCKETS);
    localparam int WIRE_W  = 32;
    localparam int KIND_W  = 2;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [KIND_W-1:0] KIND_AND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_XOR = 2'd1;

    typedef struct packed {
        logic [WIRE_W-1:0] left;
        logic [WIRE_W-1:0] right;
        logic [KIND_W-1:0] kind;
        logic [WIRE_W-1:0] outw;
    } t_way;

    typedef struct packed {
        logic [WAYS-1:0]       valid;
        t_way [WAYS-1:0]       way;
    } t_row;

    typedef enum logic [1:0] {
        HSEL_LEFT  = 2'd0,
        HSEL_RIGHT = 2'd1,
        HSEL_KIND  = 2'd2
    } t_hsel;

    typedef struct packed {
        logic  clr_we;
        logic  load;
        logic  hash_en;
        t_hsel hash_sel;
        logic  rd_en;
        logic  commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

// ----- design/gshd_if.sv -----
// Handshake channel interfaces: gate request, result and configuration write.
interface gshd_req_if import gshd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WIRE_W-1:0] left_wire;
    logic [WIRE_W-1:0] right_wire;
    logic [KIND_W-1:0] gate_kind;
    modport source (output valid, left_wire, right_wire, gate_kind, input ready);
    modport sink   (input valid, left_wire, right_wire, gate_kind, output ready);
endinterface

interface gshd_res_if import gshd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WIRE_W-1:0] out_wire;
    logic              was_duplicate;
    logic [WIRE_W-1:0] norm_left;
    logic [WIRE_W-1:0] norm_right;
    logic              not_stored;
    modport source (output valid, out_wire, was_duplicate, norm_left, norm_right,
                    not_stored, input ready);
    modport sink   (input valid, out_wire, was_duplicate, norm_left, norm_right,
                    not_stored, output ready);
endinterface

interface gshd_cfg_if import gshd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WIRE_W-1:0] first_wire;
    modport source (output valid, first_wire, input ready);
    modport sink   (input valid, first_wire, output ready);
endinterface

// ----- design/gate_structural_hash_dedup.sv -----
// Top level of the gate structural hash deduplicator.
// Each gate request is ordered (AND/XOR put the lower wire left), hashed with 32-bit
// FNV-1a over left, right and kind, and looked up in a 1024-bucket, 4-way table;
// a hit returns the stored wire, a miss allocates the next wire and stores the gate in
// the lowest free way (or flags not_stored when the bucket is full). From acceptance to a
// registered result an item is captured, passes three times through the single shared
// 32x32 hash multiplier, reads the table, and is compared and written back once the
// result register is free. A new request is taken once the previous one has committed,
// while its result may still wait in the output register. After reset the table is
// cleared one bucket a cycle, all 1024 buckets, before the first request is accepted;
// first_wire writes are taken only while the block is idle (the cycles in which a
// request would be accepted) and load the wire counter.
module gate_structural_hash_dedup import gshd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gshd_req_if.sink   i_req,
    gshd_res_if.source o_res,
    gshd_cfg_if.sink   i_cfg
);

    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    gshd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    gshd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_left_wire     (i_req.left_wire),
        .i_right_wire    (i_req.right_wire),
        .i_gate_kind     (i_req.gate_kind),
        .i_cfg_valid     (i_cfg.valid && req_ready),
        .i_first_wire    (i_cfg.first_wire),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_out_wire      (o_res.out_wire),
        .o_was_duplicate (o_res.was_duplicate),
        .o_norm_left     (o_res.norm_left),
        .o_norm_right    (o_res.norm_right),
        .o_not_stored    (o_res.not_stored)
    );

    assign i_req.ready = req_ready;
    // take counter loads only while no item is in flight
    assign i_cfg.ready = req_ready;

    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> sts.out_free)
        else $error("commit while result register is occupied");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_we, cmd.load, cmd.hash_en, cmd.rd_en, cmd.commit}))
        else $error("more than one datapath command at once");

    a_no_accept_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_en |=> !i_req.ready)
        else $error("request accepted before lookup committed");

    a_clear_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_we |-> !i_req.ready)
        else $error("request accepted during table clear");

endmodule

// ----- design/gshd_ctrl.sv -----
// Sequencer: table clear after reset, then accept, hash, read and commit per item.
module gshd_ctrl import gshd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_sts i_sts,
    output logic o_req_ready,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_H_A   = 7'b0000100,
        S_H_B   = 7'b0001000,
        S_H_K   = 7'b0010000,
        S_READ  = 7'b0100000,
        S_CMP   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.hash_sel = HSEL_LEFT;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_H_A;
                end
            end
            S_H_A: begin
                o_cmd.hash_en = 1'b1;
                n_state = S_H_B;
            end
            S_H_B: begin
                o_cmd.hash_en  = 1'b1;
                o_cmd.hash_sel = HSEL_RIGHT;
                n_state = S_H_K;
            end
            S_H_K: begin
                o_cmd.hash_en  = 1'b1;
                o_cmd.hash_sel = HSEL_KIND;
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                // hold until the result register can take the item
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

// ----- design/gshd_dp.sv -----
// Datapath: ordering, FNV-1a hash, bucket table, way compare, wire counter, result register.
module gshd_dp import gshd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [WIRE_W-1:0] i_left_wire,
    input  logic [WIRE_W-1:0] i_right_wire,
    input  logic [KIND_W-1:0] i_gate_kind,
    input  logic              i_cfg_valid,
    input  logic [WIRE_W-1:0] i_first_wire,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [WIRE_W-1:0] o_out_wire,
    output logic              o_was_duplicate,
    output logic [WIRE_W-1:0] o_norm_left,
    output logic [WIRE_W-1:0] o_norm_right,
    output logic              o_not_stored
);

    t_row mem [BUCKETS];

    logic [WIRE_W-1:0] r_a, r_b;
    logic [KIND_W-1:0] r_k;
    logic [31:0]       r_h;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_clr_addr;
    t_row              r_row;
    logic [WIRE_W-1:0] r_next;
    logic              r_out_valid;

    logic              swap;
    logic [31:0]       mul_in;
    logic [WAYS-1:0]   hit_vec;
    logic              hit, has_free;
    logic [WIRE_W-1:0] hit_wire;
    t_row              wr_row;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_row              mem_wdata;

    assign swap = ((i_gate_kind == KIND_AND) || (i_gate_kind == KIND_XOR)) &&
                  (i_left_wire > i_right_wire);

    always_comb begin
        case (i_cmd.hash_sel)
            HSEL_LEFT:  mul_in = r_h ^ r_a;
            HSEL_RIGHT: mul_in = r_h ^ r_b;
            HSEL_KIND:  mul_in = r_h ^ {{(32-KIND_W){1'b0}}, r_k};
            default:    mul_in = r_h;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= swap ? i_right_wire : i_left_wire;
            r_b <= swap ? i_left_wire  : i_right_wire;
            r_k <= i_gate_kind;
            r_h <= FNV_BASIS;
        end else if (i_cmd.hash_en) begin
            r_h <= mul_in * FNV_PRIME;
        end
        if (i_cmd.rd_en) begin
            r_idx <= r_h[IDX_W-1:0];
            r_row <= mem[r_h[IDX_W-1:0]];
        end
    end

    // compare ways; pick the lowest free way for a new gate
    always_comb begin
        hit_wire = '0;
        has_free = 1'b0;
        wr_row   = r_row;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = r_row.valid[w] && (r_row.way[w].left == r_a) &&
                         (r_row.way[w].right == r_b) && (r_row.way[w].kind == r_k);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_wire = r_row.way[w].outw;
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (!r_row.valid[w] && !has_free) begin
                has_free = 1'b1;
                wr_row.valid[w]      = 1'b1;
                wr_row.way[w].left  = r_a;
                wr_row.way[w].right = r_b;
                wr_row.way[w].kind  = r_k;
                wr_row.way[w].outw  = r_next;
            end
        end
        hit = |hit_vec;
    end

    assign mem_we    = i_cmd.clr_we || (i_cmd.commit && !hit && has_free);
    assign mem_waddr = i_cmd.clr_we ? r_clr_addr : r_idx;
    assign mem_wdata = i_cmd.clr_we ? t_row'('0) : wr_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_we) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.commit && !hit) begin
                r_next <= r_next + 1'b1;
            end else if (i_cfg_valid) begin
                r_next <= i_first_wire;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_out_wire      <= hit ? hit_wire : r_next;
            o_was_duplicate <= hit;
            o_norm_left     <= r_a;
            o_norm_right    <= r_b;
            o_not_stored    <= !hit && !has_free;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.clr_last = (r_clr_addr == IDX_W'(BUCKETS - 1));

endmodule
